/* hw/rtl/trc_pkg.sv */
`default_nettype none

package trc_pkg;

	localparam int unsigned LETTERS   = 26;
	localparam int unsigned ROTORS    = 3;
	localparam int unsigned LETTER_W  = 5;
	localparam int unsigned CHAR_W    = 8;
	localparam int unsigned SEL_W     = 2;
	localparam int unsigned COUNT_W   = 16;
	localparam logic [CHAR_W-1:0] LOWER_A = 8'd97;
	localparam int unsigned DEF_MIDDLE_STEP_PERIOD = 24;

	typedef enum logic {
		OP_LOAD   = 1'b0,
		OP_CIPHER = 1'b1
	} op_t;

	typedef logic [LETTER_W-1:0] letter_t;
	typedef letter_t [ROTORS-1:0] offsets_t;

	// one cipher item on its way through the pipeline, with the offsets it saw at entry
	typedef struct packed {
		logic              letter;
		letter_t           c;
		logic [CHAR_W-1:0] ch;
		offsets_t          off;
	} stage_t;

	typedef struct packed {
		logic step;
		logic clear;
	} step_ctl_t;

	function automatic letter_t add_mod26(input letter_t a, input letter_t b);
		logic [LETTER_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= (LETTER_W+1)'(LETTERS)) s = s - (LETTER_W+1)'(LETTERS);
		return s[LETTER_W-1:0];
	endfunction

	function automatic letter_t sub_mod26(input letter_t a, input letter_t b);
		logic [LETTER_W:0] d;
		d = {1'b0, a} + (LETTER_W+1)'(LETTERS) - {1'b0, b};
		if (d >= (LETTER_W+1)'(LETTERS)) d = d - (LETTER_W+1)'(LETTERS);
		return d[LETTER_W-1:0];
	endfunction

	function automatic letter_t reflect(input letter_t a);
		return LETTER_W'(LETTERS - 1) - a;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/three_rotor_cipher.sv */
`default_nettype none

// Three-rotor letter cipher, streaming in and out.
// Input s_*: s_tuser is the opcode (load a wiring entry or encipher a byte).
//   A load writes rotor_select/wiring_position/wiring_letter into the forward
//   and inverse tables and zeroes all rotor offsets; it gives no result.
//   A load with an out-of-range field is dropped. A cipher transaction gives
//   exactly one result on m_*: the enciphered letter, or char_in unchanged.
// Throughput: one cipher transaction per cycle while m_tready keeps the
//   pipeline moving. Seven registers: the input register plus one stage per
//   rotor table lookup (three forward, three inverse).
// A load is held off while a cipher transaction sits in stages 1 to 6: it is
//   taken only after the last cipher transaction has left stage 6, which takes
//   longer while m_tready low holds results back in those stages.
// m_tready low: results collect in the empty stages; s_tready drops for cipher
//   transactions only when all seven stages hold data.
// Reset (arst_n low): pipeline empty, offsets and step count zero. Wiring
//   tables are not cleared and must be loaded before use.
module three_rotor_cipher import trc_pkg::*; #(
	parameter int unsigned MIDDLE_STEP_PERIOD = DEF_MIDDLE_STEP_PERIOD
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,  // rotor_select[1:0], wiring_position[6:2],
	                                   // wiring_letter[11:7], char_in[19:12], zero pad
	input  wire logic        s_tuser,  // opcode[0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata   // char_out[7:0]
);

	logic [SEL_W-1:0]  in_sel;
	letter_t           in_pos, in_let;
	logic [CHAR_W-1:0] in_ch, ch_rel;
	logic in_fire, cipher_fire, load_fire, load_ok, busy;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_s6, rdy_s7;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	stage_t d_s1, d_s2, d_s3, d_s4, d_s5, d_s6, d_s7;
	stage_t nx_s1, nx_s2, nx_s3, nx_s4, nx_s5, nx_s6, nx_s7;
	offsets_t  offsets;
	step_ctl_t step_ctl;
	letter_t   fwd_addr [ROTORS];
	letter_t   fwd_data [ROTORS];
	letter_t   inv_addr [ROTORS];
	letter_t   inv_data [ROTORS];
	logic      rotor_we [ROTORS];

	assign in_sel = s_tdata[1:0];
	assign in_pos = s_tdata[6:2];
	assign in_let = s_tdata[11:7];
	assign in_ch  = s_tdata[19:12];

	always_comb begin
		rdy_s7 = !v_s7 || m_tready;
		rdy_s6 = !v_s6 || rdy_s7;
		rdy_s5 = !v_s5 || rdy_s6;
		rdy_s4 = !v_s4 || rdy_s5;
		rdy_s3 = !v_s3 || rdy_s4;
		rdy_s2 = !v_s2 || rdy_s3;
		rdy_s1 = !v_s1 || rdy_s2;
	end

	// stages 1 to 6 still read the tables
	assign busy     = v_s1 || v_s2 || v_s3 || v_s4 || v_s5 || v_s6;
	assign s_tready = rdy_s1 && ((s_tuser == OP_CIPHER) || !busy);

	assign in_fire     = s_tvalid && s_tready;
	assign cipher_fire = in_fire && (s_tuser == OP_CIPHER);
	assign load_fire   = in_fire && (s_tuser == OP_LOAD);
	assign load_ok     = load_fire && (in_sel < SEL_W'(ROTORS))
		&& (in_pos < LETTER_W'(LETTERS)) && (in_let < LETTER_W'(LETTERS));

	assign step_ctl.step  = cipher_fire;
	assign step_ctl.clear = load_ok;

	trc_stepper #(
		.MIDDLE_STEP_PERIOD(MIDDLE_STEP_PERIOD)
	) u_stepper (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (step_ctl),
		.offsets(offsets)
	);

	assign fwd_addr[0] = add_mod26(d_s1.c, d_s1.off[0]);
	assign fwd_addr[1] = add_mod26(d_s2.c, d_s2.off[1]);
	assign fwd_addr[2] = add_mod26(d_s3.c, d_s3.off[2]);
	assign inv_addr[2] = d_s4.c;
	assign inv_addr[1] = d_s5.c;
	assign inv_addr[0] = d_s6.c;

	for (genvar k = 0; k < ROTORS; k++) begin : g_rotor
		assign rotor_we[k] = load_ok && (in_sel == SEL_W'(k));

		trc_rotor u_rotor (
			.clk      (clk),
			.we       (rotor_we[k]),
			.wr_pos   (in_pos),
			.wr_letter(in_let),
			.fwd_addr (fwd_addr[k]),
			.fwd_data (fwd_data[k]),
			.inv_addr (inv_addr[k]),
			.inv_data (inv_data[k])
		);
	end

	always_comb begin
		ch_rel       = in_ch - LOWER_A;
		nx_s1.letter = (in_ch >= LOWER_A) && (in_ch < LOWER_A + CHAR_W'(LETTERS));
		nx_s1.c      = ch_rel[LETTER_W-1:0];
		nx_s1.ch     = in_ch;
		nx_s1.off    = offsets;

		nx_s2   = d_s1;
		nx_s2.c = fwd_data[0];
		nx_s3   = d_s2;
		nx_s3.c = fwd_data[1];
		nx_s4   = d_s3;
		nx_s4.c = reflect(fwd_data[2]);
		nx_s5   = d_s4;
		nx_s5.c = sub_mod26(inv_data[2], d_s4.off[2]);
		nx_s6   = d_s5;
		nx_s6.c = sub_mod26(inv_data[1], d_s5.off[1]);
		nx_s7   = d_s6;
		nx_s7.c = sub_mod26(inv_data[0], d_s6.off[0]);
		if (d_s6.letter) nx_s7.ch = LOWER_A + {3'b000, nx_s7.c};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= cipher_fire;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
			if (rdy_s6) v_s6 <= v_s5;
			if (rdy_s7) v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && cipher_fire) d_s1 <= nx_s1;
		if (rdy_s2 && v_s1) d_s2 <= nx_s2;
		if (rdy_s3 && v_s2) d_s3 <= nx_s3;
		if (rdy_s4 && v_s3) d_s4 <= nx_s4;
		if (rdy_s5 && v_s4) d_s5 <= nx_s5;
		if (rdy_s6 && v_s5) d_s6 <= nx_s6;
		if (rdy_s7 && v_s6) d_s7 <= nx_s7;
	end

	assign m_tvalid = v_s7;
	assign m_tdata  = d_s7.ch;

`ifndef SYNTHESIS
	a_letter_out: assert property (@(posedge clk) disable iff (!arst_n)
		v_s7 && d_s7.letter |-> (d_s7.ch >= LOWER_A)
		&& (d_s7.ch < LOWER_A + CHAR_W'(LETTERS)))
		else $error("enciphered letter outside a to z");

	a_load_clears: assert property (@(posedge clk) disable iff (!arst_n)
		load_ok |=> offsets == '0)
		else $error("offsets not cleared by load");

	a_load_no_hazard: assert property (@(posedge clk) disable iff (!arst_n)
		load_fire |=> !v_s1 && !v_s2 && !v_s3 && !v_s4 && !v_s5 && !v_s6)
		else $error("table write while cipher transactions in flight");
`endif

endmodule

`default_nettype wire

/* hw/rtl/trc_rotor.sv */
`default_nettype none

// Forward and inverse wiring of one rotor, one read port each.
module trc_rotor import trc_pkg::*; (
	input  wire logic    clk,
	input  wire logic    we,
	input  wire letter_t wr_pos,
	input  wire letter_t wr_letter,
	input  wire letter_t fwd_addr,
	output letter_t      fwd_data,
	input  wire letter_t inv_addr,
	output letter_t      inv_data
);

	letter_t fwd_q [LETTERS];
	letter_t inv_q [LETTERS];

	always_ff @(posedge clk) begin
		if (we) begin
			fwd_q[wr_pos]    <= wr_letter;
			inv_q[wr_letter] <= wr_pos;
		end
	end

	assign fwd_data = fwd_q[fwd_addr];
	assign inv_data = inv_q[inv_addr];

endmodule

`default_nettype wire

/* hw/rtl/trc_stepper.sv */
`default_nettype none

// Rotor offsets and the odometer count that drives them.
module trc_stepper import trc_pkg::*; #(
	parameter int unsigned MIDDLE_STEP_PERIOD = DEF_MIDDLE_STEP_PERIOD
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire step_ctl_t ctl,
	output offsets_t       offsets
);

	localparam int unsigned PERIOD_SQ = MIDDLE_STEP_PERIOD * MIDDLE_STEP_PERIOD;
	localparam int unsigned M1_W      = $clog2(MIDDLE_STEP_PERIOD);
	localparam int unsigned M2_W      = $clog2(PERIOD_SQ);

	logic [COUNT_W-1:0] count_q, count_nx;
	logic [M1_W-1:0]    m1_q, m1_nx;
	logic [M2_W-1:0]    m2_q, m2_nx;
	offsets_t           off_q;
	logic               wrap;

	// residues restart with the count when it wraps to zero
	always_comb begin
		count_nx = count_q + COUNT_W'(1);
		wrap     = (count_nx == '0);
		if (wrap || m1_q == M1_W'(MIDDLE_STEP_PERIOD - 1)) m1_nx = '0;
		else m1_nx = m1_q + M1_W'(1);
		if (wrap || m2_q == M2_W'(PERIOD_SQ - 1)) m2_nx = '0;
		else m2_nx = m2_q + M2_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			m1_q    <= '0;
			m2_q    <= '0;
			off_q   <= '0;
		end else if (ctl.clear) begin
			off_q <= '0;
		end else if (ctl.step) begin
			count_q  <= count_nx;
			m1_q     <= m1_nx;
			m2_q     <= m2_nx;
			off_q[0] <= add_mod26(off_q[0], LETTER_W'(1));
			if (m1_nx == '0) off_q[1] <= add_mod26(off_q[1], LETTER_W'(1));
			if (m2_nx == '0) off_q[2] <= add_mod26(off_q[2], LETTER_W'(1));
		end
	end

	assign offsets = off_q;

`ifndef SYNTHESIS
	a_off_range: assert property (@(posedge clk) disable iff (!arst_n)
		off_q[0] < LETTER_W'(LETTERS) && off_q[1] < LETTER_W'(LETTERS)
		&& off_q[2] < LETTER_W'(LETTERS))
		else $error("rotor offset out of range");

	a_m1_follows: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.step && !ctl.clear && m1_nx == '0 |=> off_q[1] != $past(off_q[1]))
		else $error("middle rotor did not advance");
`endif

endmodule

`default_nettype wire

/* test/three_rotor_cipher_checker.sv */
`default_nettype none

// Watches both streams of the rotor cipher, keeps its own copy of the rotor
// tables and offsets, and checks every output transaction in order.
module three_rotor_cipher_checker import trc_pkg::*; #(
	parameter int unsigned MIDDLE_STEP_PERIOD = DEF_MIDDLE_STEP_PERIOD
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [23:0] s_tdata,  // rotor_select[1:0], wiring_position[6:2],
	                                   // wiring_letter[11:7], char_in[19:12], zero pad
	input  wire logic        s_tuser,  // opcode[0]
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [7:0]  m_tdata,  // char_out[7:0]
	output int               errors,
	output int               pending
);

	letter_t           fwd_map [ROTORS][LETTERS];
	letter_t           inv_map [ROTORS][LETTERS];
	letter_t           wheel_pos [ROTORS];
	logic [COUNT_W-1:0] step_cnt;
	logic [CHAR_W-1:0] expected_chars [$];
	logic [CHAR_W-1:0] want_char;
	logic [SEL_W-1:0]  in_sel;
	letter_t           in_pos;
	letter_t           in_letter;
	logic [CHAR_W-1:0] in_char;

	initial errors = 0;
	initial pending = 0;

	task automatic report_mismatch(input string what, input logic [7:0] got,
		input logic [7:0] want);
		$display("tb_three_rotor_cipher: MISMATCH %s: got %02h, want %02h", what, got, want);
		errors++;
	endtask

	function automatic logic [CHAR_W-1:0] encipher_byte(input logic [CHAR_W-1:0] b);
		int unsigned c;
		if (b < LOWER_A || b >= LOWER_A + LETTERS) return b;
		c = b - LOWER_A;
		for (int k = 0; k < ROTORS; k++) c = fwd_map[k][(c + wheel_pos[k]) % LETTERS];
		c = LETTERS - 1 - c;
		for (int k = ROTORS - 1; k >= 0; k--)
			c = (inv_map[k][c] + LETTERS - wheel_pos[k]) % LETTERS;
		return CHAR_W'(c + LOWER_A);
	endfunction

	// odometer stepping, driven by the count after its increment
	task automatic advance_wheels();
		step_cnt = step_cnt + 1'b1;
		wheel_pos[0] = letter_t'((wheel_pos[0] + 1) % LETTERS);
		if (step_cnt % MIDDLE_STEP_PERIOD == 0)
			wheel_pos[1] = letter_t'((wheel_pos[1] + 1) % LETTERS);
		if (step_cnt % (MIDDLE_STEP_PERIOD * MIDDLE_STEP_PERIOD) == 0)
			wheel_pos[2] = letter_t'((wheel_pos[2] + 1) % LETTERS);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < ROTORS; k++) wheel_pos[k] = '0;
			step_cnt = '0;
			expected_chars.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_chars.size() == 0) begin
					report_mismatch("unexpected output transaction", m_tdata, 8'h00);
				end else begin
					want_char = expected_chars.pop_front();
					if (m_tdata !== want_char) report_mismatch("char_out", m_tdata, want_char);
				end
			end
			if (s_tvalid && s_tready) begin
				in_sel    = s_tdata[1:0];
				in_pos    = s_tdata[6:2];
				in_letter = s_tdata[11:7];
				in_char   = s_tdata[19:12];
				if (op_t'(s_tuser) == OP_CIPHER) begin
					expected_chars.push_back(encipher_byte(in_char));
					advance_wheels();
				end else if (in_sel < ROTORS && in_pos < LETTERS && in_letter < LETTERS) begin
					fwd_map[in_sel][in_pos] = in_letter;
					inv_map[in_sel][in_letter] = in_pos;
					for (int k = 0; k < ROTORS; k++) wheel_pos[k] = '0;
				end
			end
		end
		pending = expected_chars.size();
	end

endmodule

`default_nettype wire

/* test/tb_three_rotor_cipher.sv */
`default_nettype none

module tb_three_rotor_cipher;
	import trc_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int RANDOM_ITEMS   = 2000;
	localparam int QUIET_FROM     = 1800;
	localparam int STALL_AT       = 700;
	localparam int STALL_CYCLES   = 60;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;
	int          fail_cnt;
	int          pending_cnt;

	bit          quiet;
	bit          stall_req;
	bit          stall_done;
	int          idle_cycles;
	int          n_cipher;
	int          n_load;
	int          n_reload;
	letter_t     perm [ROTORS][LETTERS];

	three_rotor_cipher DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	three_rotor_cipher_checker u_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.errors   (fail_cnt),
		.pending  (pending_cnt)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// offer one transaction and hold it until accepted
	task automatic push_item(input op_t op, input logic [1:0] sel, input logic [4:0] pos,
		input logic [4:0] letter, input logic [7:0] ch, input bit may_idle);
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {4'b0000, ch, letter, pos, sel};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (op == OP_CIPHER) n_cipher++;
		else n_load++;
		if (may_idle && !quiet && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
	endtask

	// cipher transactions carry random junk in the load fields
	task automatic cipher_item(input logic [7:0] ch, input bit may_idle);
		push_item(OP_CIPHER, 2'($urandom), 5'($urandom), 5'($urandom), ch, may_idle);
	endtask

	function automatic logic [7:0] any_letter();
		return 8'(LOWER_A + $urandom_range(0, LETTERS - 1));
	endfunction

	task automatic load_rotor(input int r);
		int      j;
		letter_t t;
		for (int i = 0; i < LETTERS; i++) perm[r][i] = letter_t'(i);
		for (int i = LETTERS - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = perm[r][i];
			perm[r][i] = perm[r][j];
			perm[r][j] = t;
		end
		for (int i = 0; i < LETTERS; i++)
			push_item(OP_LOAD, 2'(r), 5'(i), perm[r][i], 8'($urandom), 1'b1);
		n_reload++;
	endtask

	// receiver: random holdoff bursts, one long stall on request
	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (stall_req && !stall_done) begin
				m_tready <= 1'b0;
				repeat (STALL_CYCLES) @(posedge clk);
				stall_done = 1'b1;
				m_tready <= 1'b1;
			end else if (!quiet && $urandom_range(0, 4) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("tb_three_rotor_cipher: watchdog expired, %0d results outstanding",
					pending_cnt);
				$display("tb_three_rotor_cipher: done, errors");
				$finish;
			end
		end
	end

	initial begin
		int roll;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tuser   = OP_LOAD;
		s_tdata   = '0;
		quiet     = 1'b0;
		stall_req = 1'b0;
		stall_done = 1'b0;
		idle_cycles = 0;
		n_cipher  = 0;
		n_load    = 0;
		n_reload  = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every table entry gets written before any letter is enciphered
		for (int r = 0; r < ROTORS; r++) load_rotor(r);

		cipher_item(8'd97, 1'b1);
		cipher_item(8'd122, 1'b1);
		cipher_item(8'd96, 1'b1);
		cipher_item(8'd123, 1'b1);
		cipher_item(8'h00, 1'b1);
		cipher_item(8'hff, 1'b1);
		cipher_item(8'd113, 1'b1);
		// out-of-range loads are dropped and must leave the offsets alone
		push_item(OP_LOAD, 2'd3, 5'd0, 5'd0, 8'h00, 1'b1);
		push_item(OP_LOAD, 2'd0, 5'd26, 5'd0, 8'hff, 1'b1);
		push_item(OP_LOAD, 2'd1, 5'd31, 5'd5, 8'h55, 1'b1);
		push_item(OP_LOAD, 2'd2, 5'd4, 5'd26, 8'haa, 1'b1);
		push_item(OP_LOAD, 2'd0, 5'd7, 5'd31, 8'h0f, 1'b1);
		cipher_item(8'd97, 1'b1);
		cipher_item(8'd98, 1'b1);
		// duplicate letter in a rotor: inverse keeps the last position written
		push_item(OP_LOAD, 2'd1, 5'd0, perm[1][1], 8'h3c, 1'b1);
		cipher_item(8'd98, 1'b1);
		cipher_item(any_letter(), 1'b1);
		push_item(OP_LOAD, 2'd2, 5'd25, 5'd25, 8'hc3, 1'b1);
		push_item(OP_LOAD, 2'd0, 5'd0, 5'd0, 8'h81, 1'b1);
		cipher_item(8'd122, 1'b1);
		cipher_item(8'h80, 1'b1);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			quiet = (i >= QUIET_FROM);
			if (i == STALL_AT) begin
				stall_req = 1'b1;
				repeat (40) cipher_item(any_letter(), 1'b0);
			end
			roll = $urandom_range(0, 999);
			if (roll < 4)
				load_rotor($urandom_range(0, ROTORS - 1));
			else if (roll < 12)
				push_item(OP_LOAD, 2'($urandom_range(0, 3)), 5'($urandom_range(0, 31)),
					5'($urandom_range(0, 31)), 8'($urandom), 1'b1);
			else if (roll < 800)
				cipher_item(any_letter(), 1'b1);
			else
				cipher_item(8'($urandom), 1'b1);
		end
		s_tvalid <= 1'b0;

		while (pending_cnt != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("tb_three_rotor_cipher: %0d cipher and %0d load transactions, %0d rotor reloads",
			n_cipher, n_load, n_reload);
		$display("tb_three_rotor_cipher: bad loads, non-letters, duplicate wiring, long output stall");
		if (fail_cnt == 0)
			$display("tb_three_rotor_cipher: done, clean");
		else
			$display("tb_three_rotor_cipher: done, errors");
		$finish;
	end

endmodule

`default_nettype wire
